### sv/spg_pkg.sv
package spg_pkg;

    // Field widths fixed by the item format
    localparam int DIM_W   = 6;
    localparam int COL_W   = 5;
    localparam int WORD_W  = 31;
    localparam int OP_W    = 2;
    localparam int POS_W   = 6;

    // Command queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;

    // Opcodes of an input item
    localparam logic [OP_W-1:0] OP_LOAD_DIR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_NUM = 2'd1;
    localparam logic [OP_W-1:0] OP_GEN      = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_DIMENSIONS    = 2'd0;
    localparam logic [1:0] REG_COLUMN_LIMIT  = 2'd1;
    localparam logic [1:0] REG_FRACTION_BITS = 2'd2;

    typedef enum logic [1:0] {
        K_LOAD_DIR = 2'd0,
        K_LOAD_NUM = 2'd1,
        K_GEN      = 2'd2
    } t_kind;

    // Classified command as it travels through the queue
    typedef struct packed {
        t_kind              kind;
        logic               in_range;
        logic [DIM_W-1:0]   dim;
        logic [COL_W-1:0]   col;
        logic [WORD_W-1:0]  value;
    } t_job;

    // One result item
    typedef struct packed {
        logic [DIM_W-1:0]   out_dim;
        logic [WORD_W-1:0]  coordinate;
        logic               last_of_point;
        logic               too_many_calls;
    } t_result;

    // 1-based position of the lowest clear bit, 32 when all bits are set
    function automatic logic [POS_W-1:0] lowest_zero(input logic [WORD_W-1:0] count);
        logic [POS_W-1:0] pos;
        pos = 6'd32;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!count[i]) begin
                pos = POS_W'(i + 1);
            end
        end
        return pos;
    endfunction

    // Numerator as a 0.31 fraction, saturating at or above one
    function automatic logic [WORD_W-1:0] scale_num(input logic [WORD_W-1:0] num,
                                                    input logic [COL_W-1:0]  fb);
        logic [COL_W-1:0] sh;
        sh = 5'd31 - fb;
        if ((num >> fb) != '0) begin
            return '1;
        end
        return num << sh;
    endfunction

endpackage

### sv/spg_ram.sv
module spg_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 40,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/spg_front.sv
module spg_front #(
    parameter int MAX_DIMENSIONS = 40,
    parameter int MAX_COLUMNS    = 31
) (
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_op,
    input  logic [5:0]             i_dim_index,
    input  logic [4:0]             i_column_index,
    input  logic [30:0]            i_load_value,
    input  logic                   i_full,
    output logic                   o_push,
    output spg_pkg::t_job          o_job
);
    import spg_pkg::*;

    logic w_dim_ok;
    logic w_col_ok;

    // Range checks against the table size
    assign w_dim_ok = {1'b0, i_dim_index} < 7'(MAX_DIMENSIONS);
    assign w_col_ok = {1'b0, i_column_index} < 6'(MAX_COLUMNS);

    assign o_ready = !i_full;

    // Classify the item; drop the unused opcode here
    always_comb begin
        o_job.dim   = i_dim_index;
        o_job.col   = i_column_index;
        o_job.value = i_load_value;
        o_push      = i_valid && !i_full;
        unique case (i_op)
            OP_LOAD_DIR: begin
                o_job.kind     = K_LOAD_DIR;
                o_job.in_range = w_dim_ok && w_col_ok;
            end
            OP_LOAD_NUM: begin
                o_job.kind     = K_LOAD_NUM;
                o_job.in_range = w_dim_ok;
            end
            OP_GEN: begin
                o_job.kind     = K_GEN;
                o_job.in_range = 1'b1;
            end
            OP_NONE: begin
                o_job.kind     = K_GEN;
                o_job.in_range = 1'b0;
                o_push         = 1'b0;
            end
            default: begin
                o_job.kind     = K_GEN;
                o_job.in_range = 1'b0;
                o_push         = 1'b0;
            end
        endcase
    end

endmodule

### sv/spg_queue.sv
module spg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  spg_pkg::t_job   i_job,
    output logic            o_full,
    input  logic            i_pop,
    output spg_pkg::t_job   o_job,
    output logic            o_empty
);
    import spg_pkg::*;

    t_job           r_slot [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_count;
    logic [QAW:0]   n_count;

    assign o_full  = r_count == (QAW + 1)'(QDEPTH);
    assign o_empty = r_count == '0;
    assign o_job   = r_slot[r_rp];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |-> !i_push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW + 1)'(QDEPTH))
        else $error("queue count out of bounds");
`endif

endmodule

### sv/spg_back.sv
module spg_back #(
    parameter int MAX_DIMENSIONS = 40,
    parameter int MAX_COLUMNS    = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spg_pkg::t_job     i_job,
    input  logic              i_empty,
    output logic              o_pop,
    input  logic [5:0]        i_dimensions,
    input  logic [4:0]        i_column_limit,
    input  logic [4:0]        i_fraction_bits,
    output logic              o_valid,
    input  logic              i_ready,
    output spg_pkg::t_result  o_result
);
    import spg_pkg::*;

    localparam int TDEPTH = MAX_DIMENSIONS * MAX_COLUMNS;
    localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int NAW    = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FIND  = 4'b0010,
        S_CHECK = 4'b0100,
        S_RUN   = 4'b1000
    } t_state;

    t_state                    r_state, n_state;
    logic [WORD_W-1:0]         r_counter, n_counter;
    logic [POS_W-1:0]          r_pos;
    logic [DIM_W-1:0]          r_d, n_d;
    logic [DIM_W-1:0]          r_last, n_last;
    logic [TAW-1:0]            r_addr, n_addr;
    logic [MAX_DIMENSIONS-1:0] r_num_valid;

    // Read in flight: data returns from both memories next cycle
    logic                      r_inflight;
    logic [DIM_W-1:0]          r_pd;
    logic                      r_plast;
    logic                      r_pvalid;

    // Output buffer of two results
    t_result                   r_ofifo [2];
    logic                      r_wp, r_rp;
    logic [1:0]                r_occ;

    logic                      w_pop_out;
    logic                      w_space;
    logic                      w_issue;
    logic                      w_err;
    logic                      w_push;
    t_result                   w_push_data;
    logic [6:0]                w_ndim;
    logic [TAW-1:0]            w_load_addr;
    logic                      w_dir_we;
    logic                      w_num_we;
    logic [NAW-1:0]            w_num_waddr;
    logic [WORD_W-1:0]         w_num_wdata;
    logic [WORD_W-1:0]         w_dir_rdata;
    logic [WORD_W-1:0]         w_num_rdata;
    logic [WORD_W-1:0]         w_num_new;
    logic                      w_load_num;

    // Output handshake and credit for a new read
    assign w_pop_out = o_valid && i_ready;
    assign w_space   = (({1'b0, r_occ} + {2'b0, r_inflight}) < 3'd2) || w_pop_out;

    // Take a command only when no read is in flight
    assign o_pop = (r_state == S_IDLE) && !i_empty && !r_inflight;

    assign w_load_addr = TAW'(i_job.dim * MAX_COLUMNS + i_job.col);
    assign w_dir_we    = o_pop && (i_job.kind == K_LOAD_DIR) && i_job.in_range;
    assign w_load_num  = o_pop && (i_job.kind == K_LOAD_NUM);

    assign w_err = (r_pos > {1'b0, i_column_limit}) || (r_pos > POS_W'(MAX_COLUMNS));

    // Clamp the dimension count to 1..MAX_DIMENSIONS
    always_comb begin
        w_ndim = {1'b0, i_dimensions};
        if (w_ndim == '0) begin
            w_ndim = 7'd1;
        end else if (w_ndim > 7'(MAX_DIMENSIONS)) begin
            w_ndim = 7'(MAX_DIMENSIONS);
        end
    end

    assign w_issue = (r_state == S_RUN) && w_space;

    // Combine returned words
    assign w_num_new = (r_pvalid ? w_num_rdata : '0) ^ w_dir_rdata;

    // Numerator write: in-flight update or start load, never both
    assign w_num_we    = r_inflight || (w_load_num && i_job.in_range);
    assign w_num_wdata = r_inflight ? w_num_new : i_job.value;
    assign w_num_waddr = r_inflight ? r_pd[NAW-1:0] : i_job.dim[NAW-1:0];

    spg_ram #(.WIDTH(WORD_W), .DEPTH(TDEPTH)) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (w_dir_we),
        .i_waddr (w_load_addr),
        .i_wdata (i_job.value),
        .i_re    (w_issue),
        .i_raddr (r_addr),
        .o_rdata (w_dir_rdata)
    );

    spg_ram #(.WIDTH(WORD_W), .DEPTH(MAX_DIMENSIONS)) u_num_ram (
        .i_clk   (i_clk),
        .i_we    (w_num_we),
        .i_waddr (w_num_waddr),
        .i_wdata (w_num_wdata),
        .i_re    (w_issue),
        .i_raddr (r_d[NAW-1:0]),
        .o_rdata (w_num_rdata)
    );

    // Result to push: a coordinate or the error item
    always_comb begin
        w_push_data.out_dim        = r_pd;
        w_push_data.coordinate     = scale_num(w_num_new, i_fraction_bits);
        w_push_data.last_of_point  = r_plast;
        w_push_data.too_many_calls = 1'b0;
        w_push                     = r_inflight;
        if ((r_state == S_CHECK) && w_err && w_space) begin
            w_push                     = 1'b1;
            w_push_data.out_dim        = '0;
            w_push_data.coordinate     = '0;
            w_push_data.last_of_point  = 1'b1;
            w_push_data.too_many_calls = 1'b1;
        end
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_counter = r_counter;
        n_d       = r_d;
        n_last    = r_last;
        n_addr    = r_addr;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    if (i_job.kind == K_LOAD_NUM) begin
                        n_counter = '0;
                    end
                    if (i_job.kind == K_GEN) begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_err) begin
                    if (w_space) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_d       = '0;
                    n_last    = DIM_W'(w_ndim - 7'd1);
                    n_addr    = TAW'(r_pos - 1'b1);
                    n_counter = r_counter + 1'b1;
                    n_state   = S_RUN;
                end
            end
            S_RUN: begin
                if (w_issue) begin
                    n_d    = r_d + 1'b1;
                    n_addr = r_addr + TAW'(MAX_COLUMNS);
                    if (r_d == r_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_counter   <= '0;
            r_num_valid <= '0;
            r_inflight  <= 1'b0;
            r_wp        <= 1'b0;
            r_rp        <= 1'b0;
            r_occ       <= '0;
        end else begin
            r_state    <= n_state;
            r_counter  <= n_counter;
            r_inflight <= w_issue;
            if (w_num_we) begin
                r_num_valid[w_num_waddr] <= 1'b1;
            end
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop_out) begin
                r_rp <= !r_rp;
            end
            r_occ <= r_occ + {1'b0, w_push} - {1'b0, w_pop_out};
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_d    <= n_d;
        r_last <= n_last;
        r_addr <= n_addr;
        if (r_state == S_FIND) begin
            r_pos <= lowest_zero(r_counter);
        end
        if (w_issue) begin
            r_pd     <= r_d;
            r_plast  <= r_d == r_last;
            r_pvalid <= r_num_valid[r_d[NAW-1:0]];
        end
        if (w_push) begin
            r_ofifo[r_wp] <= w_push_data;
        end
    end

    assign o_valid  = r_occ != '0;
    assign o_result = r_ofifo[r_rp];

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= 2'd2)
        else $error("output buffer overrun");
    a_busy_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) || r_inflight |-> !o_pop)
        else $error("command taken while a point is in progress");
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.too_many_calls |->
            o_result.last_of_point && (o_result.coordinate == '0))
        else $error("malformed error result");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) && !w_err |=> r_counter == WORD_W'($past(r_counter) + 1'b1))
        else $error("call counter did not advance by one");
`endif

endmodule

### sv/sobol_point_generator.sv
// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  ------------------------------------------
// input     in         i_valid / o_ready      i_op, i_dim_index, i_column_index,
//                                             i_load_value
// result    out        o_valid / i_ready      o_out_dim, o_coordinate, o_last_of_point,
//                                             o_too_many_calls
// config    in         psel/penable/pready    paddr, pwdata, pwrite, prdata
//
// A load item takes effect when the back end takes it; an erroring generate item finds its
// column, fails the check and pushes its error result. A generate item is taken, finds the
// column and checks it against the limit, then issues one direction and numerator read per
// dimension, one per cycle while the output has buffer space; the last read is written back.
// Up to four commands wait in the queue while a point is in progress.
// Reset is synchronous; the numerators read as zero until written, with no clearing pass.
// A stalled result side holds reads back through a two-entry output buffer.
module sobol_point_generator #(
    parameter int MAX_DIMENSIONS = 40,
    parameter int MAX_COLUMNS    = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [5:0]  i_dim_index,
    input  logic [4:0]  i_column_index,
    input  logic [30:0] i_load_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_out_dim,
    output logic [30:0] o_coordinate,
    output logic        o_last_of_point,
    output logic        o_too_many_calls,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import spg_pkg::*;

    logic [5:0] r_dimensions;
    logic [4:0] r_column_limit;
    logic [4:0] r_fraction_bits;
    logic [1:0] w_index;
    logic       w_cfg_we;
    logic       w_push;
    logic       w_full;
    logic       w_pop;
    logic       w_empty;
    t_job       w_in_job;
    t_job       w_q_job;
    t_result    w_result;

    // Configuration registers
    assign pready   = 1'b1;
    assign w_index  = paddr[3:2];
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimensions    <= 6'd1;
            r_column_limit  <= 5'd30;
            r_fraction_bits <= 5'd30;
        end else if (w_cfg_we) begin
            unique case (w_index)
                REG_DIMENSIONS:    r_dimensions    <= pwdata[5:0];
                REG_COLUMN_LIMIT:  r_column_limit  <= pwdata[4:0];
                REG_FRACTION_BITS: r_fraction_bits <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_DIMENSIONS:    prdata = {26'd0, r_dimensions};
            REG_COLUMN_LIMIT:  prdata = {27'd0, r_column_limit};
            REG_FRACTION_BITS: prdata = {27'd0, r_fraction_bits};
            default:           prdata = '0;
        endcase
    end

    spg_front #(
        .MAX_DIMENSIONS (MAX_DIMENSIONS),
        .MAX_COLUMNS    (MAX_COLUMNS)
    ) u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_dim_index    (i_dim_index),
        .i_column_index (i_column_index),
        .i_load_value   (i_load_value),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_job          (w_in_job)
    );

    spg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_q_job),
        .o_empty (w_empty)
    );

    spg_back #(
        .MAX_DIMENSIONS (MAX_DIMENSIONS),
        .MAX_COLUMNS    (MAX_COLUMNS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (w_q_job),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .i_dimensions    (r_dimensions),
        .i_column_limit  (r_column_limit),
        .i_fraction_bits (r_fraction_bits),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result        (w_result)
    );

    assign o_out_dim        = w_result.out_dim;
    assign o_coordinate     = w_result.coordinate;
    assign o_last_of_point  = w_result.last_of_point;
    assign o_too_many_calls = w_result.too_many_calls;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import spg_pkg::*;

    localparam int          NDIM          = 40;
    localparam int          NCOL          = 31;
    localparam int          CYCLE_LIMIT   = 1500000;
    localparam int          SETTLE_CYCLES = 50;
    localparam int          PHASE_ITEMS   = 70;
    localparam logic [30:0] WORD_MASK     = 31'h7FFF_FFFF;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic [1:0]  i_op           = OP_NONE;
    logic [5:0]  i_dim_index    = '0;
    logic [4:0]  i_column_index = '0;
    logic [30:0] i_load_value   = '0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [5:0]  o_out_dim;
    logic [30:0] o_coordinate;
    logic        o_last_of_point;
    logic        o_too_many_calls;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [3:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: direction words, numerators, call counter and registers
    logic [30:0] dir_word  [NDIM][NCOL];
    bit          dir_known [NDIM][NCOL];
    logic [30:0] numer     [NDIM];
    logic [30:0] call_count;
    logic [5:0]  cfg_dims;
    logic [4:0]  cfg_col_limit;
    logic [4:0]  cfg_frac_bits;

    t_result     pending_coords[$];
    int          fail_count    = 0;
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    int unsigned cycle_count   = 0;

    sobol_point_generator uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_dim_index      (i_dim_index),
        .i_column_index   (i_column_index),
        .i_load_value     (i_load_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_dim        (o_out_dim),
        .o_coordinate     (o_coordinate),
        .o_last_of_point  (o_last_of_point),
        .o_too_many_calls (o_too_many_calls),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    // 1-based position of the lowest clear bit of the counter, 32 if none
    function automatic int unsigned first_clear_pos(input logic [30:0] count);
        int unsigned pos;
        pos = 1;
        while (count[0] && pos < 32) begin
            count = count >> 1;
            pos++;
        end
        return pos;
    endfunction

    // Numerator as a 0.31 fraction; saturate at 1.0 and above
    function automatic logic [30:0] to_fraction(input logic [30:0] num, input logic [4:0] fb);
        logic [61:0] wide;
        if ({31'b0, num} >= (62'd1 << fb)) begin
            return WORD_MASK;
        end
        wide = {31'b0, num} << (31 - fb);
        return wide[30:0];
    endfunction

    function automatic int unsigned active_dims();
        if (cfg_dims == 0) begin
            return 1;
        end
        if (cfg_dims > NDIM) begin
            return NDIM;
        end
        return cfg_dims;
    endfunction

    function automatic logic [30:0] rand_word();
        return 31'($urandom()) >> $urandom_range(0, 31);
    endfunction

    // Update predictor state for one accepted item and queue the coordinates it yields
    function automatic void predict_item(input logic [1:0] op, input logic [5:0] dim,
                                         input logic [4:0] col, input logic [30:0] val);
        int unsigned pos;
        int unsigned n;
        t_result     r;
        case (op)
            OP_LOAD_DIR: begin
                if (dim < NDIM && col < NCOL) begin
                    dir_word[dim][col]  = val;
                    dir_known[dim][col] = 1'b1;
                end
            end
            OP_LOAD_NUM: begin
                if (dim < NDIM) begin
                    numer[dim] = val;
                end
                call_count = '0;
            end
            OP_GEN: begin
                pos = first_clear_pos(call_count);
                if (pos > cfg_col_limit || pos > NCOL) begin
                    r.out_dim        = '0;
                    r.coordinate     = '0;
                    r.last_of_point  = 1'b1;
                    r.too_many_calls = 1'b1;
                    pending_coords.push_back(r);
                end else begin
                    n = active_dims();
                    for (int d = 0; d < n; d++) begin
                        numer[d]         = numer[d] ^ dir_word[d][pos-1];
                        r.out_dim        = 6'(d);
                        r.coordinate     = to_fraction(numer[d], cfg_frac_bits);
                        r.last_of_point  = (d + 1 == n);
                        r.too_many_calls = 1'b0;
                        pending_coords.push_back(r);
                    end
                    call_count = call_count + 1;
                end
            end
            default: ;
        endcase
    endfunction

    // Offer one item, hold it until accepted, then predict
    task automatic send_item(input logic [1:0] op, input logic [5:0] dim,
                             input logic [4:0] col, input logic [30:0] val);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_dim_index    <= dim;
        i_column_index <= col;
        i_load_value   <= val;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        predict_item(op, dim, col, val);
    endtask

    // Generate one point; first fill any direction word it would read unwritten
    task automatic gen_point();
        int unsigned pos;
        int unsigned n;
        pos = first_clear_pos(call_count);
        if (pos <= cfg_col_limit && pos <= NCOL) begin
            n = active_dims();
            for (int d = 0; d < n; d++) begin
                if (!dir_known[d][pos-1]) begin
                    send_item(OP_LOAD_DIR, 6'(d), 5'(pos - 1), rand_word());
                end
            end
        end
        send_item(OP_GEN, 6'($urandom()), 5'($urandom()), 31'($urandom()));
    endtask

    // Drop valid, wait for every coordinate, then let the back end go quiet
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_coords.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (wr) begin
            case (idx)
                REG_DIMENSIONS:    cfg_dims      = wdata[5:0];
                REG_COLUMN_LIMIT:  cfg_col_limit = wdata[4:0];
                REG_FRACTION_BITS: cfg_frac_bits = wdata[4:0];
                default: ;
            endcase
        end
        // Return the bus to idle
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [5:0] dims, input logic [4:0] lim,
                              input logic [4:0] fb);
        logic [31:0] unused;
        apb_access(1'b1, REG_DIMENSIONS, 32'(dims), unused);
        apb_access(1'b1, REG_COLUMN_LIMIT, 32'(lim), unused);
        apb_access(1'b1, REG_FRACTION_BITS, 32'(fb), unused);
    endtask

    task automatic write_and_readback(input logic [1:0] idx, input logic [31:0] wdata,
                                      input logic [31:0] want);
        logic [31:0] rd;
        apb_access(1'b1, idx, wdata, rd);
        apb_access(1'b0, idx, '0, rd);
        if (rd !== want) begin
            report_error($sformatf("register %0d read %h, expected %h", idx, rd, want));
        end
    endtask

    // Registers keep only their own width
    task automatic test_register_access();
        write_and_readback(REG_DIMENSIONS, 32'hFFFF_FFFF, 32'h0000_003F);
        write_and_readback(REG_COLUMN_LIMIT, 32'hFFFF_FFFF, 32'h0000_001F);
        write_and_readback(REG_FRACTION_BITS, 32'hFFFF_FFFF, 32'h0000_001F);
        write_and_readback(REG_DIMENSIONS, 32'h0, 32'h0);
        write_and_readback(REG_COLUMN_LIMIT, 32'h0, 32'h0);
        write_and_readback(REG_FRACTION_BITS, 32'h0, 32'h0);
        set_config(6'd1, 5'd30, 5'd30);
    endtask

    // Loads, ignored addresses, unused op and saturation at the default setting
    task automatic test_loads_and_overflow();
        send_item(OP_LOAD_DIR, 6'd0, 5'd0, WORD_MASK);
        send_item(OP_LOAD_DIR, 6'd39, 5'd30, 31'h0);
        send_item(OP_LOAD_DIR, 6'd40, 5'd0, WORD_MASK);
        send_item(OP_LOAD_DIR, 6'd63, 5'd31, WORD_MASK);
        send_item(OP_LOAD_DIR, 6'd0, 5'd31, 31'h1234_5678);
        send_item(OP_NONE, 6'h3F, 5'h1F, WORD_MASK);
        gen_point();
        send_item(OP_LOAD_DIR, 6'd0, 5'd1, 31'h1);
        gen_point();
        gen_point();
        // just below one, then exactly one
        send_item(OP_LOAD_NUM, 6'd0, 5'd0, 31'h3FFF_FFFF);
        send_item(OP_LOAD_DIR, 6'd0, 5'd0, 31'h0);
        gen_point();
        send_item(OP_LOAD_NUM, 6'd0, 5'd0, 31'h4000_0000);
        gen_point();
        send_item(OP_LOAD_NUM, 6'd63, 5'd31, WORD_MASK);
        gen_point();
        settle();
    endtask

    // Calls past the column limit fail without touching state
    task automatic test_column_limit();
        set_config(6'd2, 5'd1, 5'd31);
        gen_point();
        gen_point();
        gen_point();
        send_item(OP_LOAD_NUM, 6'd40, 5'd0, WORD_MASK);
        gen_point();
        settle();
        set_config(6'd0, 5'd0, 5'd0);
        gen_point();
        send_item(OP_LOAD_NUM, 6'd1, 5'd0, 31'h0);
        gen_point();
        settle();
    endtask

    // Runs of generate items between start items, with some stray loads and unused ops
    task automatic test_random_traffic(input logic [5:0] dims, input logic [4:0] lim,
                                       input logic [4:0] fb, input int n_items);
        int          counted;
        int unsigned r;
        logic [5:0]  dim;
        logic [4:0]  col;
        set_config(dims, lim, fb);
        counted = 0;
        while (counted < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                dim = ($urandom_range(0, 9) != 0) ? 6'($urandom_range(0, NDIM - 1))
                                                  : 6'($urandom_range(NDIM, 63));
                send_item(OP_LOAD_NUM, dim, 5'($urandom()), rand_word());
                counted++;
            end else if (r < 18) begin
                dim = 6'($urandom_range(0, NDIM - 1));
                col = 5'($urandom_range(0, NCOL - 1));
                if ($urandom_range(0, 6) == 0) begin
                    dim = 6'($urandom_range(0, 63));
                    col = 5'h1F;
                end else if ($urandom_range(0, 6) == 0) begin
                    dim = 6'($urandom_range(NDIM, 63));
                end
                send_item(OP_LOAD_DIR, dim, col, rand_word());
                counted++;
            end else if (r < 21) begin
                send_item(OP_NONE, 6'($urandom()), 5'($urandom()), 31'($urandom()));
            end else begin
                gen_point();
                counted++;
            end
        end
        settle();
    endtask

    // Check each coordinate against the oldest prediction; stall at random
    always @(posedge i_clk) begin : check_coords
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_coords.size() == 0) begin
                report_error($sformatf("unexpected item dim=%0d coord=%h last=%b err=%b",
                                       o_out_dim, o_coordinate, o_last_of_point,
                                       o_too_many_calls));
            end else begin
                want = pending_coords.pop_front();
                if (o_out_dim !== want.out_dim) begin
                    report_error($sformatf("out_dim %0d, expected %0d",
                                           o_out_dim, want.out_dim));
                end
                if (o_coordinate !== want.coordinate) begin
                    report_error($sformatf("coordinate %h, expected %h (dim %0d)",
                                           o_coordinate, want.coordinate, want.out_dim));
                end
                if (o_last_of_point !== want.last_of_point) begin
                    report_error($sformatf("last_of_point %b, expected %b (dim %0d)",
                                           o_last_of_point, want.last_of_point,
                                           want.out_dim));
                end
                if (o_too_many_calls !== want.too_many_calls) begin
                    report_error($sformatf("too_many_calls %b, expected %b",
                                           o_too_many_calls, want.too_many_calls));
                end
            end
        end
        i_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    initial begin
        logic [5:0] ph_dims [6];
        logic [4:0] ph_lim  [6];
        logic [4:0] ph_fb   [6];
        ph_dims = '{6'd40, 6'd3, 6'd0, 6'd63, 6'd7, 6'd41};
        ph_lim  = '{5'd30, 5'd2, 5'd31, 5'd4, 5'd0, 5'd1};
        ph_fb   = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd30, 5'd20};

        // Predictor starts from the reset state
        for (int d = 0; d < NDIM; d++) begin
            numer[d] = '0;
            for (int c = 0; c < NCOL; c++) begin
                dir_word[d][c]  = '0;
                dir_known[d][c] = 1'b0;
            end
        end
        call_count    = '0;
        cfg_dims      = 6'd1;
        cfg_col_limit = 5'd30;
        cfg_frac_bits = 5'd30;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_loads_and_overflow();
        test_column_limit();

        // Sender idles lightly then heavily, then no idling on either side
        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin
                    src_idle_pct  = 23;
                    sink_idle_pct = 82;
                end
                1: begin
                    src_idle_pct  = 82;
                    sink_idle_pct = 23;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            test_random_traffic(ph_dims[ph], ph_lim[ph], ph_fb[ph], PHASE_ITEMS);
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
sv/spg_pkg.sv
sv/spg_ram.sv
sv/spg_front.sv
sv/spg_queue.sv
sv/spg_back.sv
sv/sobol_point_generator.sv
dv/tb_top.sv
